FILE: rtl/tlik_pkg.sv
// shared types, constants and tables of the two-link arm inverse kinematics block
`default_nettype none
package tlik_pkg;

  localparam int COORD_BITS    = 12;
  localparam int CORDIC_STAGES = 16;

  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;
  localparam int ATAN_IW = 5;

  localparam int Y_W     = ((COORD_BITS > 12) ? COORD_BITS : 12) + 1;
  localparam int SQ_W    = 2 * Y_W;
  localparam int R2_W    = SQ_W + 1;
  localparam int RAD_W   = R2_W + (R2_W % 2);
  localparam int ROOT_W  = RAD_W / 2 + 16;
  localparam int REM_W   = ROOT_W + 2;
  localparam int CD_W    = ((Y_W + 18) > (ROOT_W + 2)) ? (Y_W + 18) : (ROOT_W + 2);
  localparam int ANG_W   = 21;
  localparam int K_W     = 29;
  localparam int PROD_W  = ANG_W + K_W;
  localparam int CDEG_W  = PROD_W - 32 + 1;

  localparam logic signed [ANG_W-1:0] ANG_PI  = ANG_W'(205887);
  localparam logic [K_W-1:0]          CDEG_K  = K_W'(375493621);

  typedef enum logic [IDX_W-1:0] {
    REG_BASE_HEIGHT  = 3'd0,
    REG_LINK_LENGTH  = 3'd1,
    REG_SHOULDER_MIN = 3'd2,
    REG_SHOULDER_MAX = 3'd3,
    REG_ELBOW_MIN    = 3'd4,
    REG_ELBOW_MAX    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] target_x;
    logic signed [COORD_BITS-1:0] target_y;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] shoulder_angle;
    logic signed [15:0] elbow_angle;
    logic               feasible;
  } out_item_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic signed [CD_W-1:0]  x;
    logic signed [CD_W-1:0]  y;
    logic signed [ANG_W-1:0] z;
  } cordic_t;

  function automatic logic signed [ANG_W-1:0] atan_q16(input logic [ATAN_IW-1:0] idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      5'd0:    v = ANG_W'(51472);
      5'd1:    v = ANG_W'(30386);
      5'd2:    v = ANG_W'(16055);
      5'd3:    v = ANG_W'(8150);
      5'd4:    v = ANG_W'(4091);
      5'd5:    v = ANG_W'(2047);
      5'd6:    v = ANG_W'(1024);
      5'd7:    v = ANG_W'(512);
      5'd8:    v = ANG_W'(256);
      5'd9:    v = ANG_W'(128);
      5'd10:   v = ANG_W'(64);
      5'd11:   v = ANG_W'(32);
      5'd12:   v = ANG_W'(16);
      5'd13:   v = ANG_W'(8);
      5'd14:   v = ANG_W'(4);
      5'd15:   v = ANG_W'(2);
      5'd16:   v = ANG_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/tlik_sqrt_cell.sv
// one digit step of the pipelined integer square root
`default_nettype none
module tlik_sqrt_cell import tlik_pkg::*; (
  input  wire logic  clk,
  input  wire sqrt_t d_in,
  output sqrt_t      d_out
);

  sqrt_t            d_nxt;
  logic [REM_W-1:0] cur;
  logic [REM_W-1:0] trial;

  always_comb begin
    cur   = {d_in.rem[REM_W-3:0], d_in.rad[RAD_W-1:RAD_W-2]};
    trial = {d_in.root, 2'b01};
    d_nxt.rad = {d_in.rad[RAD_W-3:0], 2'b00};
    if (cur >= trial) begin
      d_nxt.rem  = cur - trial;
      d_nxt.root = {d_in.root[ROOT_W-2:0], 1'b1};
    end else begin
      d_nxt.rem  = cur;
      d_nxt.root = {d_in.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    d_out <= d_nxt;
  end

endmodule
`default_nettype wire

FILE: rtl/tlik_cordic_cell.sv
// one vectoring step of the pipelined cordic
`default_nettype none
module tlik_cordic_cell import tlik_pkg::*; (
  input  wire logic               clk,
  input  wire logic [ATAN_IW-1:0] stage,
  input  wire cordic_t            d_in,
  output cordic_t                 d_out
);

  cordic_t                d_nxt;
  logic signed [CD_W-1:0] xs;
  logic signed [CD_W-1:0] ys;

  always_comb begin
    xs = d_in.x >>> stage;
    ys = d_in.y >>> stage;
    if (!d_in.y[CD_W-1]) begin
      d_nxt.x = d_in.x + ys;
      d_nxt.y = d_in.y - xs;
      d_nxt.z = d_in.z + atan_q16(stage);
    end else begin
      d_nxt.x = d_in.x - ys;
      d_nxt.y = d_in.y + xs;
      d_nxt.z = d_in.z - atan_q16(stage);
    end
  end

  always_ff @(posedge clk) begin
    d_out <= d_nxt;
  end

endmodule
`default_nettype wire

FILE: rtl/two_link_arm_inverse_kinematics_top.sv
// top level: config registers, square, square root and cordic cell chains, angle post-processing
//
// Takes one target point in every clock cycle; busy stays low. Each transaction passes through
// the input and square registers, the row of square root cells (one root bit per cell), the row
// of cordic cells (one rotation per cell) and the angle post-processing registers, and gives one
// result strobe on out_valid. The receiver cannot stall the output, and results
// appear in input order. Configuration writes take effect at once and are to be made only
// while no transaction is in flight.
`default_nettype none
module two_link_arm_inverse_kinematics_top import tlik_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  output out_item_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int NS = ROOT_W;
  localparam int NC = CORDIC_STAGES;

  logic signed [11:0] base_height_r;
  logic [10:0]        link_length_r;
  logic signed [15:0] shoulder_min_r;
  logic signed [15:0] shoulder_max_r;
  logic signed [15:0] elbow_min_r;
  logic signed [15:0] elbow_max_r;

  logic in_fire;

  logic                  p1_v_r;
  logic signed [Y_W-1:0] p1_x_r, p1_y_r;
  logic [10:0]           p1_len_r;

  logic                  p2_v_r;
  logic signed [Y_W-1:0] p2_x_r, p2_y_r;
  logic [SQ_W-1:0]       p2_xx_r, p2_yy_r;
  logic [21:0]           p2_ll_r;
  logic                  p2_nz_r;

  logic [RAD_W-1:0]      r2_nxt, lim_nxt;
  sqrt_t                 sq_r0_r, sq_c0_r;
  sqrt_t                 sq_r_w [0:NS];
  sqrt_t                 sq_c_w [0:NS];
  logic                  sv_r  [0:NS];
  logic                  sok_r [0:NS];
  logic signed [Y_W-1:0] sx_r  [0:NS];
  logic signed [Y_W-1:0] sy_r  [0:NS];

  logic                    neg_nxt;
  logic signed [Y_W-1:0]   tx_nxt, ty_nxt;
  cordic_t                 ct0_r, ca0_r;
  cordic_t                 ct_w [0:NC];
  cordic_t                 ca_w [0:NC];
  logic                    cv_r    [0:NC];
  logic                    cok_r   [0:NC];
  logic                    czero_r [0:NC];
  logic signed [ANG_W-1:0] cbase_r [0:NC];

  logic signed [ANG_W-1:0] theta_nxt;
  logic                    q1_v_r, q1_ok_r;
  logic signed [ANG_W-1:0] q1_ang_r [0:3];
  logic                    q2_v_r, q2_ok_r;
  logic signed [ANG_W-1:0] q2_ang_r [0:3];
  logic                    q3_v_r, q3_ok_r;
  logic [ANG_W-1:0]        q3_mag_r [0:3];
  logic                    q3_neg_r [0:3];
  logic                    q4_v_r, q4_ok_r;
  logic [PROD_W-1:0]       q4_prod_r [0:3];
  logic                    q4_neg_r  [0:3];
  logic                    q5_v_r, q5_ok_r;
  logic signed [CDEG_W-1:0] q5_cd_r [0:3];
  logic [CDEG_W-1:0]        cd_mag_nxt [0:3];

  logic      fit1_nxt, fit2_nxt;
  out_item_t out_data_nxt;

  function automatic logic signed [ANG_W-1:0] wrap_pi(input logic signed [ANG_W-1:0] t);
    logic signed [ANG_W-1:0] v;
    v = t;
    if (v > ANG_PI) v = v - (ANG_PI <<< 1);
    if (v < -ANG_PI) v = v + (ANG_PI <<< 1);
    return v;
  endfunction

  function automatic logic fits(input logic signed [CDEG_W-1:0] s,
                                input logic signed [CDEG_W-1:0] e,
                                input logic signed [15:0] smin, input logic signed [15:0] smax,
                                input logic signed [15:0] emin, input logic signed [15:0] emax);
    return (s >= CDEG_W'(smin)) && (s <= CDEG_W'(smax)) &&
           (e >= CDEG_W'(emin)) && (e <= CDEG_W'(emax));
  endfunction

  assign busy    = 1'b0;
  assign in_fire = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_height_r  <= '0;
      link_length_r  <= 11'd150;
      shoulder_min_r <= -16'sd18000;
      shoulder_max_r <= 16'sd18000;
      elbow_min_r    <= -16'sd18000;
      elbow_max_r    <= 16'sd18000;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_BASE_HEIGHT:  base_height_r  <= cfg_data[11:0];
        REG_LINK_LENGTH:  link_length_r  <= cfg_data[10:0];
        REG_SHOULDER_MIN: shoulder_min_r <= cfg_data;
        REG_SHOULDER_MAX: shoulder_max_r <= cfg_data;
        REG_ELBOW_MIN:    elbow_min_r    <= cfg_data;
        REG_ELBOW_MAX:    elbow_max_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // cell chains
  assign sq_r_w[0] = sq_r0_r;
  assign sq_c_w[0] = sq_c0_r;
  assign ct_w[0]   = ct0_r;
  assign ca_w[0]   = ca0_r;

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    tlik_sqrt_cell u_r (.clk(clk), .d_in(sq_r_w[k]), .d_out(sq_r_w[k+1]));
    tlik_sqrt_cell u_c (.clk(clk), .d_in(sq_c_w[k]), .d_out(sq_c_w[k+1]));
  end

  for (genvar k = 0; k < NC; k++) begin : g_cordic
    tlik_cordic_cell u_t (.clk(clk), .stage(ATAN_IW'(k)), .d_in(ct_w[k]), .d_out(ct_w[k+1]));
    tlik_cordic_cell u_a (.clk(clk), .stage(ATAN_IW'(k)), .d_in(ca_w[k]), .d_out(ca_w[k+1]));
  end

  always_comb begin
    r2_nxt  = RAD_W'(p2_xx_r) + RAD_W'(p2_yy_r);
    lim_nxt = RAD_W'({p2_ll_r, 2'b00});

    neg_nxt = sx_r[NS][Y_W-1];
    tx_nxt  = neg_nxt ? -sx_r[NS] : sx_r[NS];
    ty_nxt  = neg_nxt ? -sy_r[NS] : sy_r[NS];

    theta_nxt = czero_r[NC] ? '0 : (cbase_r[NC] + ct_w[NC].z);

    for (int i = 0; i < 4; i++) begin
      cd_mag_nxt[i] = CDEG_W'(q4_prod_r[i][PROD_W-1:32]);
    end

    fit1_nxt = fits(q5_cd_r[0], q5_cd_r[1], shoulder_min_r, shoulder_max_r,
                    elbow_min_r, elbow_max_r);
    fit2_nxt = fits(q5_cd_r[2], q5_cd_r[3], shoulder_min_r, shoulder_max_r,
                    elbow_min_r, elbow_max_r);
    out_data_nxt = '0;
    if (q5_ok_r && fit1_nxt) begin
      out_data_nxt.shoulder_angle = q5_cd_r[0][15:0];
      out_data_nxt.elbow_angle    = q5_cd_r[1][15:0];
      out_data_nxt.feasible       = 1'b1;
    end else if (q5_ok_r && fit2_nxt) begin
      out_data_nxt.shoulder_angle = q5_cd_r[2][15:0];
      out_data_nxt.elbow_angle    = q5_cd_r[3][15:0];
      out_data_nxt.feasible       = 1'b1;
    end
  end

  // transaction valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r    <= 1'b0;
      p2_v_r    <= 1'b0;
      q1_v_r    <= 1'b0;
      q2_v_r    <= 1'b0;
      q3_v_r    <= 1'b0;
      q4_v_r    <= 1'b0;
      q5_v_r    <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k <= NS; k++) sv_r[k] <= 1'b0;
      for (int k = 0; k <= NC; k++) cv_r[k] <= 1'b0;
    end else begin
      p1_v_r  <= in_fire;
      p2_v_r  <= p1_v_r;
      sv_r[0] <= p2_v_r;
      for (int k = 0; k < NS; k++) sv_r[k+1] <= sv_r[k];
      cv_r[0] <= sv_r[NS];
      for (int k = 0; k < NC; k++) cv_r[k+1] <= cv_r[k];
      q1_v_r    <= cv_r[NC];
      q2_v_r    <= q1_v_r;
      q3_v_r    <= q2_v_r;
      q4_v_r    <= q3_v_r;
      q5_v_r    <= q4_v_r;
      out_valid <= q5_v_r;
    end
  end

  // payload pipeline
  always_ff @(posedge clk) begin
    p1_x_r   <= -(Y_W'(in_data.target_x));
    p1_y_r   <= Y_W'(in_data.target_y) - Y_W'(base_height_r);
    p1_len_r <= link_length_r;

    p2_x_r  <= p1_x_r;
    p2_y_r  <= p1_y_r;
    p2_xx_r <= SQ_W'(SQ_W'(p1_x_r) * SQ_W'(p1_x_r));
    p2_yy_r <= SQ_W'(SQ_W'(p1_y_r) * SQ_W'(p1_y_r));
    p2_ll_r <= 22'(p1_len_r) * 22'(p1_len_r);
    p2_nz_r <= (p1_len_r != '0);

    sq_r0_r.rad  <= r2_nxt;
    sq_r0_r.rem  <= '0;
    sq_r0_r.root <= '0;
    sq_c0_r.rad  <= lim_nxt - r2_nxt;
    sq_c0_r.rem  <= '0;
    sq_c0_r.root <= '0;
    sok_r[0] <= p2_nz_r && (r2_nxt <= lim_nxt);
    sx_r[0]  <= p2_x_r;
    sy_r[0]  <= p2_y_r;
    for (int k = 0; k < NS; k++) begin
      sok_r[k+1] <= sok_r[k];
      sx_r[k+1]  <= sx_r[k];
      sy_r[k+1]  <= sy_r[k];
    end

    ct0_r.x <= CD_W'($signed({tx_nxt, 16'd0}));
    ct0_r.y <= CD_W'($signed({ty_nxt, 16'd0}));
    ct0_r.z <= '0;
    ca0_r.x <= CD_W'($signed({1'b0, sq_c_w[NS].root}));
    ca0_r.y <= CD_W'($signed({1'b0, sq_r_w[NS].root}));
    ca0_r.z <= '0;
    czero_r[0] <= (sx_r[NS] == '0) && (sy_r[NS] == '0);
    cbase_r[0] <= !neg_nxt ? '0 : (!sy_r[NS][Y_W-1] ? ANG_PI : -ANG_PI);
    cok_r[0]   <= sok_r[NS];
    for (int k = 0; k < NC; k++) begin
      czero_r[k+1] <= czero_r[k];
      cbase_r[k+1] <= cbase_r[k];
      cok_r[k+1]   <= cok_r[k];
    end

    q1_ok_r     <= cok_r[NC];
    q1_ang_r[0] <= theta_nxt - ca_w[NC].z;
    q1_ang_r[1] <= (ca_w[NC].z <<< 1) - ANG_PI;
    q1_ang_r[2] <= theta_nxt + ca_w[NC].z - ANG_PI;
    q1_ang_r[3] <= ANG_PI - (ca_w[NC].z <<< 1);

    q2_ok_r     <= q1_ok_r;
    q2_ang_r[0] <= wrap_pi(q1_ang_r[0]);
    q2_ang_r[1] <= q1_ang_r[1];
    q2_ang_r[2] <= wrap_pi(q1_ang_r[2]);
    q2_ang_r[3] <= q1_ang_r[3];

    q3_ok_r <= q2_ok_r;
    q4_ok_r <= q3_ok_r;
    q5_ok_r <= q4_ok_r;
    for (int i = 0; i < 4; i++) begin
      q3_neg_r[i]  <= q2_ang_r[i][ANG_W-1];
      q3_mag_r[i]  <= q2_ang_r[i][ANG_W-1] ? ANG_W'(-q2_ang_r[i]) : ANG_W'(q2_ang_r[i]);
      q4_neg_r[i]  <= q3_neg_r[i];
      q4_prod_r[i] <= PROD_W'(q3_mag_r[i]) * PROD_W'(CDEG_K);
      q5_cd_r[i]   <= q4_neg_r[i] ? -$signed(cd_mag_nxt[i]) : $signed(cd_mag_nxt[i]);
    end

    out_data <= out_data_nxt;
  end

endmodule
`default_nettype wire
